>>> rtl/slir_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package slir_pkg;

  // Table depth and the widths that follow from it.
  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int COUNT_FW = 5;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_FULL   = 2'd1,
    ST_ABSENT = 2'd2
  } status_t;

  // Operation codes.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic                    ins_en;
    logic                    rem_en;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

  // What a cell hands to its right-hand neighbour.
  typedef struct packed {
    logic                    lt;
    logic signed [VAL_W-1:0] entry;
  } link_t;

endpackage

`default_nettype wire

>>> rtl/slir_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Request channel: one operation and its value per transfer.
interface slir_req_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic signed [31:0] value;

  modport source (output valid, op, value, input ready);
  modport sink   (input valid, op, value, output ready);
endinterface

`default_nettype wire

>>> rtl/slir_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Response channel: status, count and head of the table per transfer.
interface slir_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [4:0]         count;
  logic signed [31:0] smallest;
  logic               smallest_valid;

  modport source (output valid, status, count, smallest, smallest_valid, input ready);
  modport sink   (input valid, status, count, smallest, smallest_valid, output ready);
endinterface

`default_nettype wire

>>> rtl/slir_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module slir_cell (
  input  wire logic                                 clk,
  input  wire slir_pkg::cmd_t                       cmd,
  input  wire logic                                 occ,
  input  wire slir_pkg::link_t                      left,
  input  wire logic signed [slir_pkg::VAL_W-1:0]    right_entry,
  output slir_pkg::link_t                           link,
  output logic                                      hit,
  output logic signed [slir_pkg::VAL_W-1:0]         entry_next
);
  import slir_pkg::*;

  logic signed [VAL_W-1:0] entry;
  logic                    lt;

  // Local compare: this entry is stored and smaller than the command value.
  assign lt   = occ && (entry < cmd.value);
  assign link = '{lt: lt, entry: entry};

  // First stored copy of the value sits where the smaller run ends.
  assign hit = occ && left.lt && (entry == cmd.value);

  // Insert shifts right from the insertion point, remove shifts left.
  always_comb begin
    entry_next = entry;
    if (cmd.ins_en && !lt) begin
      entry_next = left.lt ? cmd.value : left.entry;
    end else if (cmd.rem_en && !lt) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

`default_nettype wire

>>> rtl/sorted_list_insert_remove.sv
`timescale 1ns / 1ps
`default_nettype none

// A result is registered and shown in the cycle after its request transfer.
// One request per cycle unless the response is held back; in the cycle of a transfer
// every chain cell compares and shifts, and the response register is the only stage.
// Reset clears the count and the response valid; cell contents are not reset.

module sorted_list_insert_remove (
  input wire logic clk,
  input wire logic rst,
  slir_req_if.sink   req,
  slir_rsp_if.source rsp
);
  import slir_pkg::*;

  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        count_next;
  logic                    accept;
  logic                    found;
  logic [CAPACITY-1:0]     occ;
  logic [CAPACITY-1:0]     hits;
  cmd_t                    cmd;
  link_t                   links [CAPACITY];
  link_t                   lefts [CAPACITY];
  logic signed [VAL_W-1:0] rights [CAPACITY];
  logic signed [VAL_W-1:0] nexts [CAPACITY];
  status_t                 status;

  // A new request is taken whenever the response register is free or draining.
  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  // Occupancy of each cell follows from the count.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      occ[i] = CNT_W'(i) < count;
    end
  end

  assign found = |hits;

  // Command broadcast to the chain.
  always_comb begin
    cmd.value  = req.value;
    cmd.ins_en = accept && (req.op == OP_INSERT) && (count < CNT_W'(CAPACITY));
    cmd.rem_en = accept && (req.op == OP_REMOVE) && found;
  end

  // Neighbour wiring; the first cell sees an open boundary on its left.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (i == 0) begin
        lefts[i] = '{lt: 1'b1, entry: '0};
      end else begin
        lefts[i] = links[i-1];
      end
      if (i == CAPACITY - 1) begin
        rights[i] = '0;
      end else begin
        rights[i] = links[i+1].entry;
      end
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    slir_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .occ         (occ[g]),
      .left        (lefts[g]),
      .right_entry (rights[g]),
      .link        (links[g]),
      .hit         (hits[g]),
      .entry_next  (nexts[g])
    );
  end

  // Count update and status of the request.
  always_comb begin
    count_next = count;
    if (cmd.ins_en) begin
      count_next = count + CNT_W'(1);
    end else if (cmd.rem_en) begin
      count_next = count - CNT_W'(1);
    end
    if (req.op == OP_INSERT) begin
      status = cmd.ins_en ? ST_DONE : ST_FULL;
    end else begin
      status = found ? ST_DONE : ST_ABSENT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // Response payload is captured with the transfer.
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.status         <= status;
      rsp.count          <= COUNT_FW'(count_next);
      rsp.smallest       <= (count_next != '0) ? nexts[0] : '0;
      rsp.smallest_valid <= (count_next != '0);
    end
  end

  // The table never holds more than its capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("count above capacity");

  // An insert into a full table is reported as rejected.
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    accept && (req.op == OP_INSERT) && (count == CNT_W'(CAPACITY))
    |=> rsp.status == ST_FULL)
    else $error("full insert not rejected");

  // A successful remove takes exactly one entry out.
  a_remove_count: assert property (@(posedge clk) disable iff (rst)
    cmd.rem_en |=> count == $past(count) - CNT_W'(1))
    else $error("remove count mismatch");

  // The head flag of a pending response agrees with the stored count.
  a_head_flag: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.smallest_valid == (count != '0))
    else $error("head flag disagrees with count");

endmodule

`default_nettype wire
